[rtl/scdc_pkg.sv]
// Shared types and constants for the scaled decimal comparator.
package scdc_pkg;

   localparam int MAX_SCALE = 28;
   localparam int MANT_BITS = 96;
   localparam int SCALE_W   = 8;
   // 10**MAX_SCALE needs 94 bits
   localparam int POW_BITS  = 94;
   localparam int MAG_W     = MANT_BITS + POW_BITS;
   localparam int CNT_W     = $clog2(MAX_SCALE + 1);

   localparam int REQ_W = 216;
   localparam int RSP_W = 8;

   localparam logic signed [1:0] ORDER_LESS    = 2'sb11;
   localparam logic signed [1:0] ORDER_EQUAL   = 2'sb00;
   localparam logic signed [1:0] ORDER_GREATER = 2'sb01;

   // One operation in flight through the scaling pipeline.
   typedef struct packed {
      logic [MAG_W-1:0]     mag_scaled;   // smaller-scale mantissa, being multiplied by ten
      logic [MANT_BITS-1:0] mag_fixed;    // larger-scale mantissa, untouched
      logic [CNT_W-1:0]     cnt;          // multiplications by ten still to do
      logic                 swap;         // 1: scaled side is operand b
      logic                 both_neg;
      logic                 decided;      // signs alone settle the order
      logic signed [1:0]    early_order;
      logic                 invalid;
   } stage_type;

endpackage

[rtl/scdc_scale_stage.sv]
// One pipeline stage: conditional multiply by ten with a valid/ready register slice.
module scdc_scale_stage
   import scdc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic      valid_ff, valid_in;
   stage_type data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   assign valid_in = in_ready ? in_valid : valid_ff;

   // x*10 = (x << 3) + (x << 1)
   always_comb begin
      data_in = in_data;
      if (in_data.cnt != '0) begin
         data_in.mag_scaled = (in_data.mag_scaled << 3) + (in_data.mag_scaled << 1);
         data_in.cnt        = in_data.cnt - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/scaled_decimal_compare_unit.sv]
// Top level of the scaled decimal comparator: operand decode, scaling pipeline, compare.
//
//  channel  | direction | tdata fields (lowest bit up)
//  ---------+-----------+------------------------------------------------------------
//  req_     | in        | a_mant_lo 64, a_mant_hi 32, a_scale 8, a_negative 1,
//           |           | b_mant_lo 64, b_mant_hi 32, b_scale 8, b_negative 1, pad 6
//  rsp_     | out       | order 2 (signed), invalid 1, pad 5
//
// One request accepted per cycle unless the output stalls; it passes the decode register,
// one multiply-by-ten stage per possible scale step and the compare/output register.
// Each pipeline register has its own valid bit and a local ready, so bubbles are
// squeezed out while the output waits and no request is dropped or duplicated.
// Synchronous active-high reset clears only the valid bits.
module scaled_decimal_compare_unit
   import scdc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // a_mant_lo, a_mant_hi, a_scale, a_negative,
                                         // b_mant_lo, b_mant_hi, b_scale, b_negative
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // order, invalid
);

   // ---------------- request unpack ----------------
   logic [MANT_BITS-1:0] a_mant, b_mant;
   logic [SCALE_W-1:0]   a_scale, b_scale, scale_diff;
   logic                 a_negative, b_negative;

   assign a_mant     = req_tdata[95:0];
   assign a_scale    = req_tdata[103:96];
   assign a_negative = req_tdata[104];
   assign b_mant     = req_tdata[200:105];
   assign b_scale    = req_tdata[208:201];
   assign b_negative = req_tdata[209];

   // ---------------- stage 0: decode ----------------
   // Pick the operand with the smaller scale to be multiplied up; signs that differ
   // (and not both zero) decide the order right away.
   stage_type dec_data;

   always_comb begin
      dec_data             = '0;
      dec_data.invalid     = (a_scale > SCALE_W'(MAX_SCALE)) || (b_scale > SCALE_W'(MAX_SCALE));
      dec_data.swap        = a_scale > b_scale;
      scale_diff           = dec_data.swap ? (a_scale - b_scale) : (b_scale - a_scale);
      dec_data.cnt         = dec_data.invalid ? '0 : scale_diff[CNT_W-1:0];
      dec_data.mag_scaled  = MAG_W'(dec_data.swap ? b_mant : a_mant);
      dec_data.mag_fixed   = dec_data.swap ? a_mant : b_mant;
      dec_data.both_neg    = a_negative && b_negative;
      dec_data.decided     = (a_negative != b_negative) && ((a_mant != '0) || (b_mant != '0));
      dec_data.early_order = a_negative ? ORDER_LESS : ORDER_GREATER;
   end

   // Pipeline links: index 0 is the decode register, 1..MAX_SCALE the scale stages.
   logic      stg_valid [0:MAX_SCALE];
   logic      stg_ready [0:MAX_SCALE];
   stage_type stg_data  [0:MAX_SCALE];

   logic      dec_valid_ff;
   stage_type dec_data_ff;
   logic      out_ready;

   assign req_tready   = !dec_valid_ff || stg_ready[0];
   assign stg_valid[0] = dec_valid_ff;
   assign stg_data[0]  = dec_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (req_tready) begin
         dec_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         dec_data_ff <= dec_data;
      end
   end

   // ---------------- stages 1..MAX_SCALE: multiply by ten ----------------
   for (genvar i = 1; i <= MAX_SCALE; i++) begin : g_scale
      scdc_scale_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i-1]),
         .in_ready  (stg_ready[i-1]),
         .in_data   (stg_data[i-1]),
         .out_valid (stg_valid[i]),
         .out_ready (stg_ready[i]),
         .out_data  (stg_data[i])
      );
   end

   assign stg_ready[MAX_SCALE] = out_ready;

   // ---------------- final stage: magnitude compare into output register ----------------
   stage_type         fin;
   logic [MAG_W-1:0]  mag_a, mag_b;
   logic signed [1:0] cmp_order, order_in;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   assign fin   = stg_data[MAX_SCALE];
   assign mag_a = fin.swap ? MAG_W'(fin.mag_fixed) : fin.mag_scaled;
   assign mag_b = fin.swap ? fin.mag_scaled : MAG_W'(fin.mag_fixed);

   always_comb begin
      priority if (mag_a > mag_b) begin
         cmp_order = ORDER_GREATER;
      end else if (mag_a < mag_b) begin
         cmp_order = ORDER_LESS;
      end else begin
         cmp_order = ORDER_EQUAL;
      end

      priority if (fin.invalid) begin
         order_in = ORDER_EQUAL;
      end else if (fin.decided) begin
         order_in = fin.early_order;
      end else if (fin.both_neg) begin
         order_in = -cmp_order;
      end else begin
         order_in = cmp_order;
      end

      rsp_data_in = {5'b0, fin.invalid, order_in};
   end

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stg_valid[MAX_SCALE];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_valid[MAX_SCALE] && out_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[rtl/scdc_checker.sv]
// Port-level checker for the scaled decimal comparator, bound to the top level.
module scdc_checker
   import scdc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   // no response may appear right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // order field is -1, 0 or 1
   a_order_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'b10)
      else $error("illegal order code");

   // invalid scale gives order zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == ORDER_EQUAL)
      else $error("invalid response with nonzero order");

   // empty output register means the whole pipe can take a request
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !$past(reset) |-> req_tready)
      else $error("request blocked while output is empty");

endmodule

bind scaled_decimal_compare_unit scdc_checker u_scdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
